>>> rtl/sljx_pkg.sv
package sljx_pkg;

  localparam int unsigned BUFFER_BYTES_DEFAULT = 512;
  localparam int unsigned FRAME_OVERHEAD       = 6;
  localparam int unsigned FRAME_LEN_W          = 10;
  localparam int unsigned CFG_IDX_W            = 2;
  localparam int unsigned CFG_DATA_W           = 8;

  localparam logic [7:0] SYNC_FIRST  = 8'hEF;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;

  localparam logic [7:0] SUCCESS_CODE_RESET    = 8'd0;
  localparam logic [7:0] ENROLL_ID_RESET       = 8'd29;
  localparam logic [7:0] VERIFY_ID_RESET       = 8'd18;
  localparam logic [7:0] LIST_USERS_ID_RESET   = 8'd36;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUCCESS_CODE  = 2'd0,
    CFG_ENROLL_ID     = 2'd1,
    CFG_VERIFY_ID     = 2'd2,
    CFG_LIST_USERS_ID = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_TOO_SHORT     = 3'd1,
    ST_BAD_SYNC      = 3'd2,
    ST_SIZE_MISMATCH = 3'd3,
    ST_PARITY_FAIL   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_OTHER      = 2'd0,
    KIND_ENROLL     = 2'd1,
    KIND_VERIFY     = 2'd2,
    KIND_LIST_USERS = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] success_code;
    logic [7:0] enroll_id;
    logic [7:0] verify_id;
    logic [7:0] list_users_id;
  } cfg_t;

  typedef struct packed {
    status_e                status;
    kind_e                  kind;
    logic [7:0]             result_code;
    logic                   enroll_ok;
    logic                   unlock;
    logic [7:0]             user_count;
    logic [FRAME_LEN_W-1:0] frame_length;
  } res_t;

endpackage

>>> rtl/sljx_in_if.sv
interface sljx_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

>>> rtl/sljx_out_if.sv
interface sljx_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [1:0] reply_kind;
  logic [7:0] result_code;
  logic       enroll_ok;
  logic       unlock;
  logic [7:0] user_count;
  logic [9:0] frame_length;

  modport source (
    output valid, output status, output reply_kind, output result_code,
    output enroll_ok, output unlock, output user_count, output frame_length,
    input ready
  );
  modport sink (
    input valid, input status, input reply_kind, input result_code,
    input enroll_ok, input unlock, input user_count, input frame_length,
    output ready
  );
endinterface

>>> rtl/sljx_frame.sv
module sljx_frame
  import sljx_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic       operation_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam int unsigned CntW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned SumW = (CntW > 17) ? CntW + 1 : 18;

  logic [CntW-1:0] byte_count_q, byte_count_d;
  logic [7:0]      parity_q, parity_d;
  logic [7:0]      sync_first_q, sync_second_q, size_high_q, size_low_q;
  logic [7:0]      reply_id_q, result_q, count_byte_q, users_q, users_d;

  logic            take;
  logic            close;
  logic [SumW-1:0] size_sum;
  status_e         status;
  kind_e           kind;
  logic            enroll_ok, unlock;

  assign close = fire_i && operation_i;
  // bytes past the buffer are dropped, not counted and not in the parity
  assign take  = fire_i && !operation_i && (byte_count_q < CntW'(BUFFER_BYTES));

  assign size_sum = SumW'({size_high_q, size_low_q}) + SumW'(FRAME_OVERHEAD);

  always_comb begin
    if (byte_count_q < CntW'(FRAME_OVERHEAD)) begin
      status = ST_TOO_SHORT;
    end else if (sync_first_q != SYNC_FIRST || sync_second_q != SYNC_SECOND) begin
      status = ST_BAD_SYNC;
    end else if (size_sum != SumW'(byte_count_q)) begin
      status = ST_SIZE_MISMATCH;
    end else if (parity_q != 8'd0) begin
      status = ST_PARITY_FAIL;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    kind      = KIND_OTHER;
    enroll_ok = 1'b0;
    unlock    = 1'b0;
    users_d   = users_q;
    if (status == ST_OK) begin
      if (reply_id_q == cfg_i.enroll_id) begin
        kind      = KIND_ENROLL;
        enroll_ok = (result_q == cfg_i.success_code);
      end else if (reply_id_q == cfg_i.verify_id) begin
        kind   = KIND_VERIFY;
        unlock = (result_q == cfg_i.success_code);
      end else if (reply_id_q == cfg_i.list_users_id) begin
        kind    = KIND_LIST_USERS;
        users_d = count_byte_q;
      end
    end
  end

  always_comb begin
    byte_count_d = byte_count_q;
    parity_d     = parity_q;
    if (close) begin
      byte_count_d = '0;
      parity_d     = 8'd0;
    end else if (take) begin
      byte_count_d = byte_count_q + CntW'(1);
      if (byte_count_q >= CntW'(2)) begin
        parity_d = parity_q ^ rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      parity_q      <= 8'd0;
      sync_first_q  <= 8'd0;
      sync_second_q <= 8'd0;
      size_high_q   <= 8'd0;
      size_low_q    <= 8'd0;
      reply_id_q    <= 8'd0;
      result_q      <= 8'd0;
      count_byte_q  <= 8'd0;
      users_q       <= 8'd0;
    end else begin
      byte_count_q <= byte_count_d;
      parity_q     <= parity_d;
      if (close) begin
        users_q <= users_d;
      end
      if (take) begin
        case (byte_count_q)
          CntW'(0): sync_first_q  <= rx_byte_i;
          CntW'(1): sync_second_q <= rx_byte_i;
          CntW'(3): size_high_q   <= rx_byte_i;
          CntW'(4): size_low_q    <= rx_byte_i;
          CntW'(5): reply_id_q    <= rx_byte_i;
          CntW'(6): result_q      <= rx_byte_i;
          CntW'(7): count_byte_q  <= rx_byte_i;
          default: ;
        endcase
      end
    end
  end

  assign res_valid_o        = close;
  assign res_o.status       = status;
  assign res_o.kind         = kind;
  assign res_o.result_code  = result_q;
  assign res_o.enroll_ok    = enroll_ok;
  assign res_o.unlock       = unlock;
  assign res_o.user_count   = users_d;
  assign res_o.frame_length = FRAME_LEN_W'(byte_count_q);

endmodule

>>> rtl/sljx_out_buf.sv
module sljx_out_buf
  import sljx_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic space_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  res_t main_q, skid_q;
  logic main_valid_q, skid_valid_q;
  logic pop;

  assign pop     = main_valid_q && ready_i;
  // a push can only land while the skid slot is empty
  assign space_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!main_valid_q || pop) begin
        if (skid_valid_q) begin
          main_valid_q <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          main_valid_q <= push_i;
        end
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || pop) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= data_i;
      end
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign valid_o = main_valid_q;
  assign data_o  = main_q;

endmodule

>>> rtl/sync_length_xor_frame_checker.sv
// Frame checker for the replies of a serial module.
// in_ch carries one item per received byte (operation 0) or an idle timeout
// (operation 1) that closes the frame. Byte items give no result; each close
// gives exactly one result item on out_ch with the check status, the reply
// kind, the result byte, the enroll and unlock flags, the latched user count
// and the stored frame length.
// One input item is taken every cycle while the output is not backed up.
// A close result is written into the output buffer and shows on out_ch once the results ahead of it are taken;
// the count, parity and capture registers update in the same cycle as the item.
// Results sit in a two-deep output buffer: while the receiver stalls the block
// keeps taking items until both slots hold results, then ready drops.
// Configuration registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// writes them only while the block is idle, which the block itself does not enforce.
// Reset clears the byte count, parity, captured bytes and the user count, and
// loads the register defaults (success 0, enroll 29, verify 18, list users 36).
module sync_length_xor_frame_checker
  import sljx_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sljx_in_if.sink               in_ch,
  sljx_out_if.source            out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic fire;
  logic res_valid;
  res_t res, out_res;
  logic space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.success_code  <= SUCCESS_CODE_RESET;
      cfg_q.enroll_id     <= ENROLL_ID_RESET;
      cfg_q.verify_id     <= VERIFY_ID_RESET;
      cfg_q.list_users_id <= LIST_USERS_ID_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SUCCESS_CODE:  cfg_q.success_code  <= cfg_wdata_i;
        CFG_ENROLL_ID:     cfg_q.enroll_id     <= cfg_wdata_i;
        CFG_VERIFY_ID:     cfg_q.verify_id     <= cfg_wdata_i;
        CFG_LIST_USERS_ID: cfg_q.list_users_id <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = space;
  assign fire        = in_ch.valid && space;

  sljx_frame #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .operation_i (in_ch.operation),
    .rx_byte_i   (in_ch.rx_byte),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sljx_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .space_o (space),
    .valid_o (out_ch.valid),
    .ready_i (out_ch.ready),
    .data_o  (out_res)
  );

  assign out_ch.status       = out_res.status;
  assign out_ch.reply_kind   = out_res.kind;
  assign out_ch.result_code  = out_res.result_code;
  assign out_ch.enroll_ok    = out_res.enroll_ok;
  assign out_ch.unlock       = out_res.unlock;
  assign out_ch.user_count   = out_res.user_count;
  assign out_ch.frame_length = out_res.frame_length;

endmodule

>>> tb/sv/sync_length_xor_frame_checker_tb.sv
module sync_length_xor_frame_checker_tb
  import sljx_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BUF_BYTES = BUFFER_BYTES_DEFAULT;
  localparam int unsigned ITEM_TARGET = 850;

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_BAD_SYNC,
    SHAPE_BAD_SIZE,
    SHAPE_BAD_PARITY,
    SHAPE_SHORT,
    SHAPE_NOISE,
    SHAPE_OVERFLOW
  } frame_shape_e;

  // tracks the frame state of the block and holds the verdicts still due
  class frame_verdict_model;
    cfg_t        cfg;
    int unsigned byte_cnt;
    logic [7:0]  parity;
    logic [7:0]  sync0;
    logic [7:0]  sync1;
    logic [7:0]  size_hi;
    logic [7:0]  size_lo;
    logic [7:0]  reply_id;
    logic [7:0]  result_b;
    logic [7:0]  count_b;
    logic [7:0]  users;
    res_t        verdicts_due[$];
    int          errors;

    function new();
      cfg.success_code  = SUCCESS_CODE_RESET;
      cfg.enroll_id     = ENROLL_ID_RESET;
      cfg.verify_id     = VERIFY_ID_RESET;
      cfg.list_users_id = LIST_USERS_ID_RESET;
      byte_cnt = 0;
      parity   = '0;
      sync0    = '0;
      sync1    = '0;
      size_hi  = '0;
      size_lo  = '0;
      reply_id = '0;
      result_b = '0;
      count_b  = '0;
      users    = '0;
      errors   = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [7:0] v);
      case (idx)
        CFG_SUCCESS_CODE:  cfg.success_code = v;
        CFG_ENROLL_ID:     cfg.enroll_id = v;
        CFG_VERIFY_ID:     cfg.verify_id = v;
        CFG_LIST_USERS_ID: cfg.list_users_id = v;
        default: ;
      endcase
    endfunction

    function void take_item(logic op, logic [7:0] b);
      res_t        v;
      int unsigned size;
      if (!op) begin
        // bytes past the buffer are dropped, count and parity untouched
        if (byte_cnt < BUF_BYTES) begin
          case (byte_cnt)
            0: sync0 = b;
            1: sync1 = b;
            3: size_hi = b;
            4: size_lo = b;
            5: reply_id = b;
            6: result_b = b;
            7: count_b = b;
            default: ;
          endcase
          if (byte_cnt >= 2) parity = parity ^ b;
          byte_cnt++;
        end
        return;
      end
      size = 32'({size_hi, size_lo});
      if (byte_cnt < FRAME_OVERHEAD) v.status = ST_TOO_SHORT;
      else if (sync0 != SYNC_FIRST || sync1 != SYNC_SECOND) v.status = ST_BAD_SYNC;
      else if (size + FRAME_OVERHEAD != byte_cnt) v.status = ST_SIZE_MISMATCH;
      else if (parity != 8'd0) v.status = ST_PARITY_FAIL;
      else v.status = ST_OK;
      v.kind      = KIND_OTHER;
      v.enroll_ok = 1'b0;
      v.unlock    = 1'b0;
      if (v.status == ST_OK) begin
        // enroll wins over verify, verify over list users
        if (reply_id == cfg.enroll_id) begin
          v.kind      = KIND_ENROLL;
          v.enroll_ok = (result_b == cfg.success_code);
        end else if (reply_id == cfg.verify_id) begin
          v.kind   = KIND_VERIFY;
          v.unlock = (result_b == cfg.success_code);
        end else if (reply_id == cfg.list_users_id) begin
          v.kind = KIND_LIST_USERS;
          users  = count_b;
        end
      end
      v.result_code  = result_b;
      v.user_count   = users;
      v.frame_length = byte_cnt[FRAME_LEN_W-1:0];
      verdicts_due.push_back(v);
      byte_cnt = 0;
      parity   = '0;
    endfunction

    task flag_mismatch(string what, logic [15:0] got_v, logic [15:0] want_v);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
      errors++;
    endtask

    task check_verdict(res_t got);
      res_t want;
      if (verdicts_due.size() == 0) begin
        flag_mismatch("result item with none due, status", 16'(got.status), 16'd0);
        return;
      end
      want = verdicts_due.pop_front();
      if (got.status !== want.status)
        flag_mismatch("status", 16'(got.status), 16'(want.status));
      if (got.kind !== want.kind)
        flag_mismatch("reply_kind", 16'(got.kind), 16'(want.kind));
      if (got.result_code !== want.result_code)
        flag_mismatch("result_code", 16'(got.result_code), 16'(want.result_code));
      if (got.enroll_ok !== want.enroll_ok)
        flag_mismatch("enroll_ok", 16'(got.enroll_ok), 16'(want.enroll_ok));
      if (got.unlock !== want.unlock)
        flag_mismatch("unlock", 16'(got.unlock), 16'(want.unlock));
      if (got.user_count !== want.user_count)
        flag_mismatch("user_count", 16'(got.user_count), 16'(want.user_count));
      if (got.frame_length !== want.frame_length)
        flag_mismatch("frame_length", 16'(got.frame_length), 16'(want.frame_length));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    quiet_mode;
  int unsigned           items_sent;

  frame_verdict_model verdicts = new();

  sljx_in_if  in_bus ();
  sljx_out_if out_bus ();

  sync_length_xor_frame_checker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[sync_length_xor_frame_checker] ERROR");
    $finish;
  end

  // receiver side, stalls in bursts
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_watch
    res_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.status       = status_e'(out_bus.status);
      got.kind         = kind_e'(out_bus.reply_kind);
      got.result_code  = out_bus.result_code;
      got.enroll_ok    = out_bus.enroll_ok;
      got.unlock       = out_bus.unlock;
      got.user_count   = out_bus.user_count;
      got.frame_length = out_bus.frame_length;
      verdicts.check_verdict(got);
    end
  end

  task automatic send_item(logic op, logic [7:0] b);
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.rx_byte   <= b;
    do @(posedge clk_i); while (!in_bus.ready);
    verdicts.take_item(op, b);
    items_sent++;
  endtask

  task automatic send_frame(frame_shape_e shape, int unsigned data_len,
                            logic [7:0] id_b, logic [7:0] res_b);
    logic [7:0]  fb[$];
    logic [7:0]  sum;
    int unsigned pos;
    if (shape == SHAPE_SHORT || shape == SHAPE_NOISE) begin
      for (int i = 0; i < data_len; i++) fb.push_back(8'($urandom));
      // often a real sync word, so a later check is the one that trips
      if (fb.size() >= 2 && $urandom_range(0, 1) == 1) begin
        fb[0] = SYNC_FIRST;
        fb[1] = SYNC_SECOND;
      end
    end else begin
      fb.push_back(SYNC_FIRST);
      fb.push_back(SYNC_SECOND);
      fb.push_back(8'($urandom));
      fb.push_back(8'(data_len >> 8));
      fb.push_back(8'(data_len));
      for (int i = 0; i < data_len; i++)
        fb.push_back(i == 0 ? id_b : (i == 1 ? res_b : 8'($urandom)));
      sum = '0;
      for (int i = 2; i < fb.size(); i++) sum = sum ^ fb[i];
      fb.push_back(sum);
      case (shape)
        SHAPE_BAD_SYNC: begin
          pos = $urandom_range(0, 1);
          fb[pos] = fb[pos] ^ 8'($urandom_range(1, 255));
        end
        SHAPE_BAD_SIZE:   fb[4] = fb[4] ^ 8'($urandom_range(1, 255));
        SHAPE_BAD_PARITY: fb[fb.size()-1] = fb[fb.size()-1] ^ 8'($urandom_range(1, 255));
        SHAPE_OVERFLOW:   repeat ($urandom_range(1, 8)) fb.push_back(8'($urandom));
        default: ;
      endcase
    end
    foreach (fb[i]) send_item(1'b0, fb[i]);
    send_item(1'b1, 8'($urandom));
  endtask

  task automatic send_random_frame(bit oversized);
    int unsigned pick;
    int unsigned len;
    logic [7:0]  id_b;
    logic [7:0]  res_b;
    pick = $urandom_range(0, 19);
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    case ($urandom_range(0, 4))
      0:       id_b = verdicts.cfg.enroll_id;
      1:       id_b = verdicts.cfg.verify_id;
      2:       id_b = verdicts.cfg.list_users_id;
      default: id_b = 8'($urandom);
    endcase
    res_b = ($urandom_range(0, 1) == 1) ? verdicts.cfg.success_code : 8'($urandom);
    if (oversized) send_frame(SHAPE_OVERFLOW, BUF_BYTES - FRAME_OVERHEAD, id_b, res_b);
    else if (pick < 10) send_frame(SHAPE_GOOD, len, id_b, res_b);
    else if (pick < 12) send_frame(SHAPE_BAD_SYNC, len, id_b, res_b);
    else if (pick < 14) send_frame(SHAPE_BAD_SIZE, len, id_b, res_b);
    else if (pick < 16) send_frame(SHAPE_BAD_PARITY, len, id_b, res_b);
    else if (pick < 18) send_frame(SHAPE_SHORT, $urandom_range(0, 5), id_b, res_b);
    else send_frame(SHAPE_NOISE, $urandom_range(6, 14), id_b, res_b);
  endtask

  // sender holds off until every verdict is in and the block has settled
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (verdicts.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [7:0] succ, logic [7:0] enr, logic [7:0] ver,
                           logic [7:0] lst);
    logic [7:0] vals[4];
    cfg_idx_e   idx;
    vals[CFG_SUCCESS_CODE]  = succ;
    vals[CFG_ENROLL_ID]     = enr;
    vals[CFG_VERIFY_ID]     = ver;
    vals[CFG_LIST_USERS_ID] = lst;
    idx = idx.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx;
      cfg_wdata <= vals[idx];
      @(posedge clk_i);
      verdicts.set_reg(idx, vals[idx]);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0]  shared_id;
    int unsigned frames;
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_SUCCESS_CODE;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.operation <= 1'b0;
    in_bus.rx_byte   <= '0;
    quiet_mode = 1'b0;
    items_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // close with nothing received
    send_item(1'b1, 8'hFF);
    send_frame(SHAPE_GOOD, 2, ENROLL_ID_RESET, SUCCESS_CODE_RESET);
    send_frame(SHAPE_GOOD, 3, LIST_USERS_ID_RESET, 8'hFF);
    // short frame reports bytes captured by the previous one
    send_frame(SHAPE_SHORT, 3, 8'h00, 8'h00);

    for (int phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        0: load_regs(8'h00, 8'h00, 8'h00, 8'h00);
        1: load_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        2: load_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        3: begin
          shared_id = 8'($urandom);
          load_regs(8'($urandom), 8'($urandom), shared_id, shared_id);
        end
        default: load_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      if (phase == 4) quiet_mode = 1'b1;
      // full buffer frame with dropped tail bytes
      if (phase == 2) send_random_frame(1'b1);
      frames = 0;
      while (phase < 4 ? frames < 7 : (items_sent < ITEM_TARGET || frames < 8)) begin
        send_random_frame(1'b0);
        frames++;
      end
    end

    in_bus.valid <= 1'b0;
    while (verdicts.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (verdicts.errors == 0 && verdicts.verdicts_due.size() == 0) begin
      $display("[sync_length_xor_frame_checker] OK");
    end else begin
      $display("[sync_length_xor_frame_checker] ERROR");
    end
    $finish;
  end

endmodule
